// ===== rtl/tanc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and coefficient tables for the three-axis notch cascade
// no dependencies

package tanc_pkg;

    localparam int NUM_AXES        = 3;
    localparam int SAMPLE_WIDTH    = 32;
    localparam int COEFF_FRAC_BITS = 30;
    localparam int NUM_STAGES      = 3;

    localparam int COEFF_W = COEFF_FRAC_BITS + 2;
    localparam int PROD_W  = SAMPLE_WIDTH + COEFF_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int STG_W   = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int TDATA_W = ((NUM_AXES * SAMPLE_WIDTH + 7) / 8) * 8;

    // q2.30 notch coefficients per stage: b0 (= b2), a1 (= b1), a2
    localparam longint Q30_B0 [NUM_STAGES] = '{64'sd845336060, 64'sd674715933, 64'sd380895493};
    localparam longint Q30_A1 [NUM_STAGES] = '{-64'sd1460611235, -64'sd650093760, 64'sd408188023};
    localparam longint Q30_A2 [NUM_STAGES] = '{64'sd616930295, 64'sd275690043, -64'sd311950837};

    // multiply-accumulate term order within one stage
    typedef logic [2:0] term_t;
    localparam term_t TERM_X0 = 3'd0;
    localparam term_t TERM_X1 = 3'd1;
    localparam term_t TERM_X2 = 3'd2;
    localparam term_t TERM_Y1 = 3'd3;
    localparam term_t TERM_Y2 = 3'd4;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEFF_W-1:0]      coeff_t;

    typedef struct packed {
        logic start;
        logic cascade;
        logic release_ok;
    } lane_ctrl_t;

    typedef struct packed {
        logic    busy;
        logic    done;
        sample_t y;
    } lane_status_t;

    // rescale a q2.30 constant to COEFF_FRAC_BITS, rounding half up
    function automatic coeff_t coeff_scale(input longint q);
        int sh;
        sh = 30 - COEFF_FRAC_BITS;
        if (sh == 0)
            return COEFF_W'(q);
        return COEFF_W'((q + (64'sd1 <<< (sh - 1))) >>> sh);
    endfunction

    // feedback terms carry the negated denominator coefficients
    function automatic coeff_t coeff_sel(input int unsigned s, input term_t t);
        coeff_t c;
        c = '0;
        case (t) inside
            TERM_X0, TERM_X2: c = coeff_scale(Q30_B0[s]);
            TERM_X1:          c = coeff_scale(Q30_A1[s]);
            TERM_Y1:          c = -coeff_scale(Q30_A1[s]);
            TERM_Y2:          c = -coeff_scale(Q30_A2[s]);
            default:          c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/tanc_lane.sv =====
`timescale 1ns / 1ps
// one axis lane: a shared multiply-accumulate that steps through the biquad stages
// depends on tanc_pkg

module tanc_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tanc_pkg::lane_ctrl_t  ctrl,
    input  tanc_pkg::sample_t     x_in,
    output tanc_pkg::lane_status_t status
);
    import tanc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_ROUND = 4'b1000
    } lane_state_t;

    lane_state_t                 state_reg, state_next;
    logic [STG_W-1:0]            stage_reg, stage_next;
    term_t                       term_reg, term_next;
    logic                        prod_vld_reg, prod_vld_next;
    logic                        done_reg, done_next;
    sample_t                     x_reg, x_next;
    sample_t                     y_reg, y_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    sample_t                     x1_reg [NUM_STAGES];
    sample_t                     x2_reg [NUM_STAGES];
    sample_t                     y1_reg [NUM_STAGES];
    sample_t                     y2_reg [NUM_STAGES];

    sample_t                     operand;
    coeff_t                      coeff;
    logic [STG_W-1:0]            last_stage;
    logic                        is_last;
    logic                        commit;
    logic signed [ACC_W-1:0]     rounded;
    logic signed [ACC_W-1:0]     sat_max;
    logic signed [ACC_W-1:0]     sat_min;
    sample_t                     y_sat;

    assign last_stage = ctrl.cascade ? STG_W'(NUM_STAGES - 1) : '0;
    assign is_last    = (stage_reg == last_stage);
    assign commit     = (state_reg == ST_ROUND) && (!is_last || ctrl.release_ok);

    always_comb
    begin
        case (term_reg)
            TERM_X0: operand = x_reg;
            TERM_X1: operand = x1_reg[stage_reg];
            TERM_X2: operand = x2_reg[stage_reg];
            TERM_Y1: operand = y1_reg[stage_reg];
            TERM_Y2: operand = y2_reg[stage_reg];
            default: operand = '0;
        endcase
        coeff = coeff_sel(int'(stage_reg), term_reg);
    end

    // floor((acc + half) / 2^k), then clamp to the sample range
    assign sat_max = ACC_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    assign sat_min = {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
    assign rounded = (acc_reg + (ACC_W'(1) <<< (COEFF_FRAC_BITS - 1))) >>> COEFF_FRAC_BITS;

    always_comb
    begin
        if (rounded > sat_max)
            y_sat = sat_max[SAMPLE_WIDTH-1:0];
        else if (rounded < sat_min)
            y_sat = sat_min[SAMPLE_WIDTH-1:0];
        else
            y_sat = rounded[SAMPLE_WIDTH-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        stage_next    = stage_reg;
        term_next     = term_reg;
        prod_vld_next = 1'b0;
        done_next     = 1'b0;
        x_next        = x_reg;
        y_next        = y_reg;
        prod_next     = prod_reg;
        acc_next      = prod_vld_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    x_next     = x_in;
                    stage_next = '0;
                    term_next  = TERM_X0;
                    acc_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                prod_next     = PROD_W'(operand * coeff);
                prod_vld_next = 1'b1;
                if (term_reg == TERM_Y2)
                    state_next = ST_DRAIN;
                else
                    term_next = term_reg + 3'd1;
            end
            ST_DRAIN:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (commit)
                begin
                    if (is_last)
                    begin
                        y_next     = y_sat;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        x_next     = y_sat;
                        stage_next = stage_reg + STG_W'(1);
                        term_next  = TERM_X0;
                        acc_next   = '0;
                        state_next = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                x1_reg[s] <= '0;
                x2_reg[s] <= '0;
                y1_reg[s] <= '0;
                y2_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            prod_vld_reg <= prod_vld_next;
            done_reg     <= done_next;
            if (commit)
            begin
                x2_reg[stage_reg] <= x1_reg[stage_reg];
                x1_reg[stage_reg] <= x_reg;
                y2_reg[stage_reg] <= y1_reg[stage_reg];
                y1_reg[stage_reg] <= y_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        term_reg  <= term_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = done_reg;
    assign status.y    = y_reg;

endmodule

// ===== rtl/tanc_merge.sv =====
`timescale 1ns / 1ps
// merge stage: gathers the lane results into one output beat and holds it
// depends on tanc_pkg

module tanc_merge (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  tanc_pkg::lane_status_t [tanc_pkg::NUM_AXES-1:0] lane_st,
    output logic                                      release_ok,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [tanc_pkg::TDATA_W-1:0]              m_tdata
);
    import tanc_pkg::*;

    logic                 valid_reg, valid_next;
    logic [TDATA_W-1:0]   data_reg, data_next;
    logic                 all_done;

    always_comb
    begin
        all_done = 1'b1;
        data_next = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            all_done = all_done & lane_st[i].done;
            data_next[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = lane_st[i].y;
        end
    end

    // lanes finish their last stage only once the output slot is free or being emptied
    assign release_ok = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (m_tready)
            valid_next = 1'b0;
        if (all_done)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (all_done)
            data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== rtl/three_axis_notch_cascade.sv =====
`timescale 1ns / 1ps
// top level of the three-axis notch cascade: mode register, axis lanes, merge stage
// depends on tanc_pkg, tanc_lane and tanc_merge

// Filters one three-axis Q16.16 sample per beat through direct-form-I biquad
// notches at 85, 170 and 340 Hz (cascade_mode = 1) or the 85 Hz notch alone
// (cascade_mode = 0); idle stages keep their history. Each axis has its own
// lane with one 32x32 multiplier that steps through the five products of a
// stage, then a drain and a round step. A new beat is taken only once the
// lanes are idle again, and the last stage waits in its round step while the
// output register is full and not being taken. The result sits in an output
// register, so the next beat can enter while it waits to be taken. Only bit 0
// of the configuration data is used; write it while the block is idle.

module three_axis_notch_cascade (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,      // cascade_mode
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tanc_pkg::TDATA_W-1:0]  s_tdata,       // accel_x, accel_y, accel_z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tanc_pkg::TDATA_W-1:0]  m_tdata        // filtered_x, filtered_y, filtered_z
);
    import tanc_pkg::*;

    logic                               mode_reg;
    logic                               release_ok;
    logic                               any_busy;
    logic [NUM_AXES-1:0]                lane_done;
    lane_ctrl_t                         ctrl;
    lane_status_t [NUM_AXES-1:0]        lane_st;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    always_comb
    begin
        any_busy = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            any_busy     = any_busy | lane_st[i].busy;
            lane_done[i] = lane_st[i].done;
        end
    end

    assign s_tready        = !any_busy;
    assign ctrl.start      = s_tvalid && s_tready;
    assign ctrl.cascade    = mode_reg;
    assign ctrl.release_ok = release_ok;

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        tanc_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .x_in   (s_tdata[g*SAMPLE_WIDTH +: SAMPLE_WIDTH]),
            .status (lane_st[g])
        );
    end

    tanc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_st    (lane_st),
        .release_ok (release_ok),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTH
    // lanes run in lockstep and finish together
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_done) |-> (&lane_done))
        else $error("axis lanes finished out of step");

    // an accepted beat keeps the lanes busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again before the lanes started");

    // a finished item always lands in the output register
    a_done_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (&lane_done) |=> m_tvalid)
        else $error("lane result lost before the output register");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for three_axis_notch_cascade: directed table, then random blocks
// depends on tanc_pkg and the rtl top level; carries its own notch predictor

module testbench;

    import tanc_pkg::sample_t;
    import tanc_pkg::TDATA_W;
    import tanc_pkg::NUM_AXES;
    import tanc_pkg::NUM_STAGES;

    typedef sample_t [NUM_AXES-1:0] axes_t;   // [0] = x in the low bits, as on tdata

    localparam bit MODE_SINGLE  = 1'b0;
    localparam bit MODE_CASCADE = 1'b1;

    localparam int STYLE_MIXED = 0;
    localparam int STYLE_SWING = 1;
    localparam int STYLE_QUIET = 2;

    localparam int ITEM_TARGET = 1150;
    localparam int CYCLE_LIMIT = 600000;
    localparam int FRAC_BITS   = 30;

    localparam logic [7:0] READY_PATTERN = 8'b1011_0010;

    // q2.30 notch coefficients per stage: b0 (= b2), a1 (= b1), a2
    localparam longint NOTCH_B0 [NUM_STAGES] = '{845336060, 674715933, 380895493};
    localparam longint NOTCH_A1 [NUM_STAGES] = '{-1460611235, -650093760, 408188023};
    localparam longint NOTCH_A2 [NUM_STAGES] = '{616930295, 275690043, -311950837};

    localparam logic signed [79:0] WIDE_HALF = 80'sd536870912;
    localparam logic signed [79:0] WIDE_MAX  = 80'sd2147483647;
    localparam logic signed [79:0] WIDE_MIN  = -80'sd2147483648;

    localparam sample_t S_MAX = 32'sh7fffffff;
    localparam sample_t S_MIN = 32'sh80000000;
    localparam sample_t S_ONE = 32'sh00010000;

    typedef struct {
        bit      mode;
        axes_t   smp;
        bit      typed;
        axes_t   want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;      // accel_x, accel_y, accel_z
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;           // filtered_x, filtered_y, filtered_z

    three_axis_notch_cascade u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // filter history, stage by axis
    sample_t hist_in1  [NUM_STAGES][NUM_AXES];
    sample_t hist_in2  [NUM_STAGES][NUM_AXES];
    sample_t hist_out1 [NUM_STAGES][NUM_AXES];
    sample_t hist_out2 [NUM_STAGES][NUM_AXES];
    bit      cascade_on = MODE_SINGLE;

    axes_t       pending_filtered [$];
    stim_row_t   directed_rows [$];
    int          error_count  = 0;
    int          result_count = 0;
    int          items_sent   = 0;
    int          cycle_count  = 0;
    int          burst_left   = 0;
    int unsigned ready_style  = 0;
    int unsigned ready_left   = 0;

    function automatic sample_t notch_stage(input int stg, input int ax, input sample_t x);
        logic signed [79:0] wx0, wx1, wx2, wy1, wy2, sum, rounded;
        sample_t y;
        wx0 = x;
        wx1 = hist_in1[stg][ax];
        wx2 = hist_in2[stg][ax];
        wy1 = hist_out1[stg][ax];
        wy2 = hist_out2[stg][ax];
        sum = NOTCH_B0[stg] * wx0 + NOTCH_A1[stg] * wx1 + NOTCH_B0[stg] * wx2
            - NOTCH_A1[stg] * wy1 - NOTCH_A2[stg] * wy2;
        rounded = (sum + WIDE_HALF) >>> FRAC_BITS;
        if (rounded > WIDE_MAX)
            y = S_MAX;
        else if (rounded < WIDE_MIN)
            y = S_MIN;
        else
            y = rounded[31:0];
        hist_in2[stg][ax]  = hist_in1[stg][ax];
        hist_in1[stg][ax]  = x;
        hist_out2[stg][ax] = hist_out1[stg][ax];
        hist_out1[stg][ax] = y;
        return y;
    endfunction

    // idle stages keep their history in single mode
    function automatic axes_t filter_sample(input axes_t smp);
        axes_t   res;
        sample_t v;
        int      nstg;
        nstg = cascade_on ? NUM_STAGES : 1;
        for (int ax = 0; ax < NUM_AXES; ax++)
        begin
            v = smp[ax];
            for (int stg = 0; stg < nstg; stg++)
                v = notch_stage(stg, ax, v);
            res[ax] = v;
        end
        return res;
    endfunction

    function automatic sample_t pick_sample(input int style, input int unsigned seq);
        int unsigned r;
        sample_t     v;
        r = $urandom_range(0, 99);
        if (r < 15)
            v = $urandom;
        else if (style == STYLE_SWING)
            v = seq[0] ? S_MAX - $urandom_range(0, 24'hffffff)
                       : S_MIN + $urandom_range(0, 24'hffffff);
        else if (style == STYLE_QUIET)
            v = $urandom_range(0, 32'h200000) - 32'h100000;
        else if (r < 35)
            v = $urandom_range(0, 32'h200000) - 32'h100000;
        else if (r < 55)
            v = $urandom_range(0, 1) ? S_MAX : S_MIN;
        else if (r < 70)
            v = $urandom_range(0, 1) ? S_MAX - $urandom_range(0, 255)
                                     : S_MIN + $urandom_range(0, 255);
        else if (r < 85)
            v = $urandom_range(0, 4) - 2;
        else if (r < 92)
            v = '0;
        else
            v = $urandom;
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input sample_t got, input sample_t want);
        error_count++;
        $display("mismatch on %s at result %0d: got %0d expected %0d",
                 what, result_count, got, want);
    endtask

    task automatic add_row(input bit mode, input sample_t x, input sample_t y, input sample_t z,
                           input bit typed, input sample_t ex, input sample_t ey,
                           input sample_t ez);
        stim_row_t row;
        row.mode  = mode;
        row.smp   = {z, y, x};
        row.typed = typed;
        row.want  = {ez, ey, ex};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // mode changes only once every pending result has drained
    task automatic set_mode(input bit mode);
        s_tvalid <= 1'b0;
        while (pending_filtered.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        cascade_on = mode;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic send_sample(input axes_t smp);
        pace_sender();
        s_tdata  <= smp;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // receiver stalls: always ready, coin flip, mostly stalled, fixed rotating pattern
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_style <= $urandom_range(0, 3);
            ready_left  <= $urandom_range(16, 200);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= READY_PATTERN[cycle_count[2:0]];
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("three_axis_notch_cascade test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        axes_t want;
        axes_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_filtered.size() == 0)
            begin
                error_count++;
                $display("result beat with nothing pending: %h", m_tdata);
            end
            else
            begin
                want = pending_filtered.pop_front();
                if (got[0] !== want[0])
                    flag_mismatch("filtered_x", got[0], want[0]);
                if (got[1] !== want[1])
                    flag_mismatch("filtered_y", got[1], want[1]);
                if (got[2] !== want[2])
                    flag_mismatch("filtered_z", got[2], want[2]);
            end
            result_count++;
        end
    end

    initial
    begin
        axes_t     smp;
        axes_t     res;
        stim_row_t row;
        int        block_len;
        int        block_style;

        for (int stg = 0; stg < NUM_STAGES; stg++)
            for (int ax = 0; ax < NUM_AXES; ax++)
            begin
                hist_in1[stg][ax]  = '0;
                hist_in2[stg][ax]  = '0;
                hist_out1[stg][ax] = '0;
                hist_out2[stg][ax] = '0;
            end

        // zero history after reset gives zero out
        add_row(MODE_SINGLE, 0, 0, 0, 1'b1, 0, 0, 0);
        add_row(MODE_SINGLE, 0, 0, 0, 1'b1, 0, 0, 0);
        // full-scale swings push the 85 Hz stage into saturation
        add_row(MODE_SINGLE, S_MAX, S_MIN, S_ONE, 1'b0, 0, 0, 0);
        add_row(MODE_SINGLE, S_MIN, S_MAX, -S_ONE, 1'b0, 0, 0, 0);
        add_row(MODE_SINGLE, S_MAX, S_MIN, 1, 1'b0, 0, 0, 0);
        add_row(MODE_SINGLE, S_MIN, S_MAX, -1, 1'b0, 0, 0, 0);
        add_row(MODE_SINGLE, S_MAX, S_MAX, S_MAX, 1'b0, 0, 0, 0);
        add_row(MODE_SINGLE, S_MAX, S_MAX, S_MAX, 1'b0, 0, 0, 0);
        add_row(MODE_SINGLE, 1, -1, 0, 1'b0, 0, 0, 0);
        add_row(MODE_SINGLE, 0, 0, 0, 1'b0, 0, 0, 0);
        add_row(MODE_CASCADE, S_MAX, S_MIN, 32'sh7fff0000, 1'b0, 0, 0, 0);
        add_row(MODE_CASCADE, S_MIN, S_MAX, 32'sh80010000, 1'b0, 0, 0, 0);
        add_row(MODE_CASCADE, S_MAX, S_MIN, S_MAX, 1'b0, 0, 0, 0);
        add_row(MODE_CASCADE, S_MIN, S_MAX, S_MIN, 1'b0, 0, 0, 0);
        add_row(MODE_CASCADE, 0, 0, 0, 1'b0, 0, 0, 0);
        add_row(MODE_CASCADE, S_ONE, -S_ONE, 32'sh00008000, 1'b0, 0, 0, 0);
        // back to single: later stages must hold their history
        add_row(MODE_SINGLE, S_MAX, 0, S_MIN, 1'b0, 0, 0, 0);
        add_row(MODE_SINGLE, S_MIN, 0, S_MAX, 1'b0, 0, 0, 0);
        add_row(MODE_SINGLE, 32'sh00012345, -32'sh00023456, 7, 1'b0, 0, 0, 0);
        add_row(MODE_CASCADE, 0, 0, 0, 1'b0, 0, 0, 0);
        add_row(MODE_CASCADE, 32'sh12345678, 32'sh80000001, 32'sh7ffffffe, 1'b0, 0, 0, 0);
        add_row(MODE_CASCADE, 0, 0, 0, 1'b0, 0, 0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(MODE_SINGLE);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.mode != cascade_on)
                set_mode(row.mode);
            send_sample(row.smp);
            res = filter_sample(row.smp);
            pending_filtered.insert(pending_filtered.size(), row.typed ? row.want : res);
        end

        while (items_sent < ITEM_TARGET)
        begin
            block_len   = $urandom_range(30, 150);
            block_style = ($urandom_range(0, 9) < 6) ? STYLE_MIXED : $urandom_range(1, 2);
            set_mode($urandom_range(0, 1) ? MODE_CASCADE : MODE_SINGLE);
            for (int n = 0; n < block_len && items_sent < ITEM_TARGET; n++)
            begin
                for (int ax = 0; ax < NUM_AXES; ax++)
                    smp[ax] = pick_sample(block_style, n + ax);
                send_sample(smp);
                pending_filtered.insert(pending_filtered.size(), filter_sample(smp));
            end
        end
        s_tvalid <= 1'b0;

        while (pending_filtered.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("three_axis_notch_cascade test passed");
        else
            $display("three_axis_notch_cascade test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tanc_pkg.sv
rtl/tanc_lane.sv
rtl/tanc_merge.sv
rtl/three_axis_notch_cascade.sv
tb/testbench.sv
